// File: hw/rtl/one_wire_bus_master_unit_defines.svh
// Assertion helpers used by the checker file.
`ifndef ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH

// Clocked assertion, disabled while reset is asserted.
`define OWBM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define OWBM_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/owbm_pkg.sv
package owbm_pkg;

    // Action codes of the input word
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_RESET = 3'd1;
    localparam logic [2:0] ACT_WRITE = 3'd2;
    localparam logic [2:0] ACT_READB = 3'd3;
    localparam logic [2:0] ACT_READ1 = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [2:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [2:0] CFG_RESET_TAIL    = 3'd2;
    localparam logic [2:0] CFG_SLOT_LOW      = 3'd3;
    localparam logic [2:0] CFG_READ_SAMPLE   = 3'd4;
    localparam logic [2:0] CFG_READ_TAIL     = 3'd5;
    localparam logic [2:0] CFG_WRITE_HOLD    = 3'd6;
    localparam logic [2:0] CFG_RECOVERY      = 3'd7;

    localparam int CFG_DATA_W = 10;
    localparam int CFG_ADDR_W = 3;

    // Bus sequencer phases
    typedef enum logic [8:0] {
        PH_IDLE     = 9'b000000001,
        PH_RST_LOW  = 9'b000000010,
        PH_RST_WAIT = 9'b000000100,
        PH_RST_TAIL = 9'b000001000,
        PH_SLOT_LOW = 9'b000010000,
        PH_WR_HOLD  = 9'b000100000,
        PH_WR_REC   = 9'b001000000,
        PH_RD_WAIT  = 9'b010000000,
        PH_RD_TAIL  = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic [9:0] reset_low;
        logic [9:0] presence_wait;
        logic [9:0] reset_tail;
        logic [5:0] slot_low;
        logic [5:0] read_sample;
        logic [6:0] read_tail;
        logic [6:0] write_hold;
        logic [5:0] recovery;
    } t_cfg;

    localparam t_cfg CFG_DEFAULT = '{
        reset_low:     10'd480,
        presence_wait: 10'd100,
        reset_tail:    10'd380,
        slot_low:      6'd2,
        read_sample:   6'd10,
        read_tail:     7'd49,
        write_hold:    7'd58,
        recovery:      6'd1
    };

    typedef struct packed {
        t_phase     phase;
        logic [9:0] cnt;
        logic [7:0] shreg;
        logic [3:0] bits;
        logic [2:0] op;
        logic       pres;
    } t_state;

    typedef struct packed {
        t_state st;
        logic   done;
    } t_adv;

    // One phase transition, taken only when the current phase has run out.
    function automatic t_adv adv_step(t_state s, t_cfg c, logic line);
        t_adv       r;
        logic [3:0] nb;
        logic       fin;
        r    = '{st: s, done: 1'b0};
        nb   = s.bits + 4'd1;
        fin  = 1'b0;
        if (s.phase != PH_IDLE && s.cnt == 10'd0) begin
            unique case (s.phase)
                PH_RST_LOW: begin
                    r.st.phase = PH_RST_WAIT;
                    r.st.cnt   = c.presence_wait;
                end
                PH_RST_WAIT: begin
                    r.st.pres  = ~line;
                    r.st.phase = PH_RST_TAIL;
                    r.st.cnt   = c.reset_tail;
                end
                PH_SLOT_LOW: begin
                    if (s.op == ACT_WRITE) begin
                        r.st.phase = PH_WR_HOLD;
                        r.st.cnt   = {3'd0, c.write_hold};
                    end else begin
                        r.st.phase = PH_RD_WAIT;
                        r.st.cnt   = {4'd0, c.read_sample};
                    end
                end
                PH_WR_HOLD: begin
                    r.st.phase = PH_WR_REC;
                    r.st.cnt   = {4'd0, c.recovery};
                end
                PH_WR_REC: begin
                    r.st.shreg = {1'b0, s.shreg[7:1]};
                    r.st.bits  = nb;
                    if (nb[3]) begin
                        fin = 1'b1;
                    end else begin
                        r.st.phase = PH_SLOT_LOW;
                        r.st.cnt   = {4'd0, c.slot_low};
                    end
                end
                PH_RD_WAIT: begin
                    if (s.op == ACT_READ1) begin
                        r.st.shreg = {7'd0, line};
                    end else begin
                        r.st.shreg = {line, s.shreg[7:1]};
                    end
                    r.st.phase = PH_RD_TAIL;
                    r.st.cnt   = {3'd0, c.read_tail};
                end
                PH_RD_TAIL: begin
                    r.st.bits = nb;
                    if (s.op == ACT_READ1 || nb[3]) begin
                        fin = 1'b1;
                    end else begin
                        r.st.phase = PH_SLOT_LOW;
                        r.st.cnt   = {4'd0, c.slot_low};
                    end
                end
                default: begin
                    fin = 1'b1;
                end
            endcase
            if (fin) begin
                r.st.phase = PH_IDLE;
                r.st.cnt   = 10'd0;
                r.done     = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/one_wire_bus_master_unit.sv
// Single-wire bus master, open-drain style.
// Input channel (i_in_valid / o_in_ready) carries one word per item: a
// one-microsecond tick, or a command (bus reset with presence detect, write
// byte, read byte, read bit) with its byte and the sensed line level.
// Output channel (o_out_valid / i_out_ready) returns one word per item: line
// drive, busy, done, presence, received data and a reject flag for commands
// that arrive while busy.
// A result word passes through the input register, then the result register.
// Throughput: one word per cycle while the receiver does not stall; the
// sequencer update for a word, including a run of phases set to zero length,
// is done combinationally between those two registers.
// Config writes (i_cfg_wr_en / i_cfg_addr / i_cfg_wdata) take effect at once
// and are meant for idle periods only.
// Reset (synchronous, active low) empties both registers, puts the sequencer
// in idle with cleared counters and loads the default timing values.
// When the receiver stalls, the result register holds its word and the input
// register keeps at most one more; o_in_ready drops once both are full.
module one_wire_bus_master_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config port
    input  logic                              i_cfg_wr_en,
    input  logic [owbm_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [owbm_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [2:0]                        i_action,
    input  logic [7:0]                        i_data_in,
    input  logic                              i_line_in,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_pull_low,
    output logic                              o_busy_res,
    output logic                              o_done_res,
    output logic                              o_presence,
    output logic [7:0]                        o_data_out,
    output logic                              o_rejected
);
    import owbm_pkg::*;

    t_cfg       r_cfg, n_cfg;
    t_state     r_st, n_st;

    logic       r_in_valid;
    logic [2:0] r_action;
    logic [7:0] r_data;
    logic       r_line;

    logic       r_out_valid;
    logic       r_pull, r_busy, r_done, r_pres, r_rej;
    logic [7:0] r_dout;

    logic       out_free;
    logic       fire;
    t_state     s0;
    t_adv       a1, a2, a3;
    logic       start;
    logic       rej;
    logic       shortcut;
    logic       done;
    logic       n_pull;
    logic [7:0] n_dout;

    assign out_free   = ~r_out_valid | i_out_ready;
    assign fire       = r_in_valid & out_free;
    assign o_in_ready = ~r_in_valid | out_free;

    // config register decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_RESET_LOW:     n_cfg.reset_low     = i_cfg_wdata;
                CFG_PRESENCE_WAIT: n_cfg.presence_wait = i_cfg_wdata;
                CFG_RESET_TAIL:    n_cfg.reset_tail    = i_cfg_wdata;
                CFG_SLOT_LOW:      n_cfg.slot_low      = i_cfg_wdata[5:0];
                CFG_READ_SAMPLE:   n_cfg.read_sample   = i_cfg_wdata[5:0];
                CFG_READ_TAIL:     n_cfg.read_tail     = i_cfg_wdata[6:0];
                CFG_WRITE_HOLD:    n_cfg.write_hold    = i_cfg_wdata[6:0];
                CFG_RECOVERY:      n_cfg.recovery      = i_cfg_wdata[5:0];
            endcase
        end
    end

    // apply the word: tick countdown, command start, or reject while busy
    always_comb begin
        s0    = r_st;
        start = 1'b0;
        rej   = 1'b0;
        case (r_action) inside
            ACT_TICK: begin
                if (r_st.phase != PH_IDLE && r_st.cnt != 10'd0) begin
                    s0.cnt = r_st.cnt - 10'd1;
                end
            end
            ACT_RESET, ACT_WRITE, ACT_READB, ACT_READ1: begin
                if (r_st.phase != PH_IDLE) begin
                    rej = 1'b1;
                end else begin
                    start    = 1'b1;
                    s0.op    = r_action;
                    s0.bits  = 4'd0;
                    s0.shreg = (r_action == ACT_WRITE) ? r_data : 8'd0;
                    if (r_action == ACT_RESET) begin
                        s0.phase = PH_RST_LOW;
                        s0.cnt   = r_cfg.reset_low;
                    end else begin
                        s0.phase = PH_SLOT_LOW;
                        s0.cnt   = {4'd0, r_cfg.slot_low};
                    end
                end
            end
            default: ;
        endcase
    end

    // a byte with every slot phase at zero length completes on its start word
    assign shortcut = start &
        ((r_action == ACT_WRITE && r_cfg.slot_low == 6'd0 &&
          r_cfg.write_hold == 7'd0 && r_cfg.recovery == 6'd0) ||
         (r_action == ACT_READB && r_cfg.slot_low == 6'd0 &&
          r_cfg.read_sample == 6'd0 && r_cfg.read_tail == 7'd0));

    // otherwise at most three expired phases can chain on one word
    assign a1 = adv_step(s0, r_cfg, r_line);
    assign a2 = adv_step(a1.st, r_cfg, r_line);
    assign a3 = adv_step(a2.st, r_cfg, r_line);

    always_comb begin
        if (shortcut) begin
            n_st       = s0;
            n_st.phase = PH_IDLE;
            n_st.cnt   = 10'd0;
            n_st.bits  = 4'd8;
            n_st.shreg = (r_action == ACT_WRITE) ? 8'd0 : {8{r_line}};
            done       = 1'b1;
        end else begin
            n_st = a3.st;
            done = a1.done | a2.done | a3.done;
        end
    end

    // result fields from the updated state
    always_comb begin
        n_pull = (n_st.phase == PH_RST_LOW) || (n_st.phase == PH_SLOT_LOW) ||
                 (n_st.phase == PH_WR_HOLD && !n_st.shreg[0]);
        if (n_st.phase == PH_IDLE && (n_st.op == ACT_READB || n_st.op == ACT_READ1)) begin
            n_dout = n_st.shreg;
        end else begin
            n_dout = 8'd0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_DEFAULT;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '{phase: PH_IDLE, cnt: 10'd0, shreg: 8'd0, bits: 4'd0,
                             op: 3'd0, pres: 1'b0};
        end else begin
            r_cfg <= n_cfg;
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (out_free) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_st        <= n_st;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_action <= i_action;
            r_data   <= i_data_in;
            r_line   <= i_line_in;
        end
        if (fire) begin
            r_pull <= n_pull;
            r_busy <= (n_st.phase != PH_IDLE);
            r_done <= done;
            r_pres <= n_st.pres;
            r_dout <= n_dout;
            r_rej  <= rej;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pull_low  = r_pull;
    assign o_busy_res  = r_busy;
    assign o_done_res  = r_done;
    assign o_presence  = r_pres;
    assign o_data_out  = r_dout;
    assign o_rejected  = r_rej;

endmodule

// File: hw/rtl/owbm_checker.sv
`include "one_wire_bus_master_unit_defines.svh"

module owbm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_pull_low,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic [7:0] o_data_out,
    input logic       o_rejected
);

    // reset empties the result register
    `OWBM_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // stalled result word holds
    `OWBM_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_data_out) && $stable(o_busy_res), "stalled result changed")

    // a reject leaves the running operation in place
    `OWBM_ASSERT(a_rej_busy, i_clk, i_rst_n, o_out_valid && o_rejected |-> o_busy_res && !o_done_res, "reject while not busy")

    // the line is driven only during an operation, and done means idle
    `OWBM_ASSERT(a_pull_busy, i_clk, i_rst_n, o_out_valid && (o_pull_low || o_done_res) |-> (o_busy_res != o_done_res) && !(o_pull_low && o_done_res), "bus drive or done inconsistent with busy")

endmodule

bind one_wire_bus_master_unit owbm_checker u_owbm_checker (.*);

// File: bench/tb_top.sv
module tb_top;
    import owbm_pkg::*;

    // spare action codes: the block ignores them
    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_MID = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam int BYTE_BITS = 8;
    localparam int SETTLE_CYCLES = 4;      // result register latency plus margin
    localparam int HOLD_CYCLES = 300;      // long receiver hold-off
    localparam int RANDOM_PHASES = 4;
    localparam int WORDS_PER_PHASE = 100;
    // bound for all words, with their gaps and stalls, plus hold-offs
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [2:0] act;
        logic [7:0] data;
        logic       line;
    } t_bus_word;

    typedef struct {
        logic       pull;
        logic       busy;
        logic       done;
        logic       pres;
        logic [7:0] data;
        logic       rej;
    } t_bus_result;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [2:0] i_action = ACT_TICK;
    logic [7:0] i_data_in = 8'h00;
    logic       i_line_in = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic       o_pull_low;
    logic       o_busy_res;
    logic       o_done_res;
    logic       o_presence;
    logic [7:0] o_data_out;
    logic       o_rejected;

    one_wire_bus_master_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_data_in   (i_data_in),
        .i_line_in   (i_line_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_pull_low  (o_pull_low),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_presence  (o_presence),
        .o_data_out  (o_data_out),
        .o_rejected  (o_rejected)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Bus master shadow state and timing registers
    t_phase     bm_phase = PH_IDLE;
    logic [9:0] bm_cnt = '0;
    logic [7:0] bm_shift = '0;
    logic [3:0] bm_bits = '0;
    logic [2:0] bm_op = '0;
    logic       bm_pres = 1'b0;
    logic [9:0] timing [8];

    t_bus_word   word_q [$];
    t_bus_result result_q [$];

    int words_queued = 0;
    int words_taken = 0;
    int results_checked = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int settings_used = 1;
    int cmds_started = 0;
    int cmds_rejected = 0;
    int ops_done = 0;
    int pres_yes = 0;
    int pres_no = 0;

    logic in_taken = 1'b0;
    bit   send_idle = 1'b1;
    bit   recv_idle = 1'b1;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    int   hold_reqs = 0;
    int   holds_started = 0;

    function automatic int reg_bits(logic [2:0] idx);
        case (idx)
            CFG_SLOT_LOW, CFG_READ_SAMPLE, CFG_RECOVERY: return 6;
            CFG_READ_TAIL, CFG_WRITE_HOLD: return 7;
            default: return 10;
        endcase
    endfunction

    function automatic int reg_min(logic [2:0] idx);
        case (idx)
            CFG_RESET_TAIL, CFG_READ_TAIL, CFG_RECOVERY: return 0;
            default: return 1;
        endcase
    endfunction

    function automatic int reg_max(logic [2:0] idx);
        return (1 << reg_bits(idx)) - 1;
    endfunction

    function automatic void go_phase(t_phase p, logic [9:0] len);
        bm_phase = p;
        bm_cnt = len;
    endfunction

    // Close the running phase; returns 1 when the whole operation is over
    function automatic bit end_phase(logic line);
        bit fin;
        fin = 1'b0;
        case (bm_phase)
            PH_RST_LOW: go_phase(PH_RST_WAIT, timing[CFG_PRESENCE_WAIT]);
            PH_RST_WAIT: begin
                bm_pres = ~line;
                go_phase(PH_RST_TAIL, timing[CFG_RESET_TAIL]);
            end
            PH_SLOT_LOW: begin
                if (bm_op == ACT_WRITE)
                    go_phase(PH_WR_HOLD, timing[CFG_WRITE_HOLD]);
                else
                    go_phase(PH_RD_WAIT, timing[CFG_READ_SAMPLE]);
            end
            PH_WR_HOLD: go_phase(PH_WR_REC, timing[CFG_RECOVERY]);
            PH_WR_REC: begin
                bm_shift = bm_shift >> 1;
                bm_bits = bm_bits + 4'd1;
                if (bm_bits >= BYTE_BITS)
                    fin = 1'b1;
                else
                    go_phase(PH_SLOT_LOW, timing[CFG_SLOT_LOW]);
            end
            PH_RD_WAIT: begin
                if (bm_op == ACT_READ1)
                    bm_shift = {7'd0, line};
                else
                    bm_shift = {line, bm_shift[7:1]};
                go_phase(PH_RD_TAIL, timing[CFG_READ_TAIL]);
            end
            PH_RD_TAIL: begin
                bm_bits = bm_bits + 4'd1;
                if (bm_op == ACT_READ1 || bm_bits >= BYTE_BITS)
                    fin = 1'b1;
                else
                    go_phase(PH_SLOT_LOW, timing[CFG_SLOT_LOW]);
            end
            default: fin = 1'b1;
        endcase
        if (fin) begin
            bm_phase = PH_IDLE;
            bm_cnt = '0;
        end
        return fin;
    endfunction

    // zero-length phases collapse into the same word
    function automatic bit run_expired(logic line);
        bit done;
        done = 1'b0;
        while (bm_phase != PH_IDLE && bm_cnt == '0)
            done = end_phase(line);
        return done;
    endfunction

    function automatic t_bus_result predict_word(logic [2:0] act, logic [7:0] data,
                                                 logic line);
        t_bus_result r;
        bit done;
        bit rej;
        done = 1'b0;
        rej = 1'b0;
        if (act == ACT_TICK) begin
            if (bm_phase != PH_IDLE) begin
                if (bm_cnt != '0)
                    bm_cnt = bm_cnt - 10'd1;
                done = run_expired(line);
            end
        end else if (act <= ACT_READ1) begin
            if (bm_phase != PH_IDLE) begin
                rej = 1'b1;
            end else begin
                bm_op = act;
                bm_bits = '0;
                bm_shift = (act == ACT_WRITE) ? data : 8'h00;
                if (act == ACT_RESET)
                    go_phase(PH_RST_LOW, timing[CFG_RESET_LOW]);
                else
                    go_phase(PH_SLOT_LOW, timing[CFG_SLOT_LOW]);
                done = run_expired(line);
            end
        end
        r.pull = (bm_phase == PH_RST_LOW) || (bm_phase == PH_SLOT_LOW) ||
                 (bm_phase == PH_WR_HOLD && !bm_shift[0]);
        r.busy = (bm_phase != PH_IDLE);
        r.done = done;
        r.pres = bm_pres;
        r.data = (bm_phase == PH_IDLE && (bm_op == ACT_READB || bm_op == ACT_READ1)) ?
                 bm_shift : 8'h00;
        r.rej = rej;
        return r;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    task automatic check_bit(string what, logic want, logic got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s mismatch, expected %0b, got %0b", $time, what, want, got);
        end
    endtask

    // Input side: offer queued words, with random gaps between them while send_idle is set
    always @(negedge i_clk) begin : feed
        t_bus_word w;
        if (!i_in_valid || in_taken) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (word_q.size() > 0) begin
                w = word_q.pop_front();
                i_action <= w.act;
                i_data_in <= w.data;
                i_line_in <= w.line;
                i_in_valid <= 1'b1;
                if (send_idle)
                    gap_left <= draw_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output side: random stalls while recv_idle is set, and requested long hold-offs
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_reqs != holds_started) begin
            holds_started <= holds_started + 1;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (recv_idle)
                stall_left <= draw_gap();
        end
    end

    // Check results against expectations, then predict newly accepted words
    always @(posedge i_clk) begin : watch
        t_bus_result want;
        t_bus_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 40)
                    $display("%0t: result word with nothing expected", $time);
            end else begin
                want = result_q.pop_front();
                check_bit("pull_low", want.pull, o_pull_low);
                check_bit("busy", want.busy, o_busy_res);
                check_bit("done", want.done, o_done_res);
                check_bit("presence", want.pres, o_presence);
                check_field("data_out", want.data, o_data_out);
                check_bit("rejected", want.rej, o_rejected);
                results_checked++;
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            if (i_action != ACT_TICK && i_action <= ACT_READ1 && bm_phase == PH_IDLE)
                cmds_started++;
            got = predict_word(i_action, i_data_in, i_line_in);
            result_q.push_back(got);
            words_taken++;
            if (got.rej)
                cmds_rejected++;
            if (got.done) begin
                ops_done++;
                if (bm_op == ACT_RESET) begin
                    if (got.pres)
                        pres_yes++;
                    else
                        pres_no++;
                end
            end
        end
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_word(logic [2:0] act, logic [7:0] data, logic line);
        t_bus_word w;
        w.act = act;
        w.data = data;
        w.line = line;
        word_q.push_back(w);
        words_queued++;
    endtask

    function automatic int ticks_for(logic [2:0] act);
        int rd_slot;
        int wr_slot;
        rd_slot = timing[CFG_SLOT_LOW] + timing[CFG_READ_SAMPLE] + timing[CFG_READ_TAIL];
        wr_slot = timing[CFG_SLOT_LOW] + timing[CFG_WRITE_HOLD] + timing[CFG_RECOVERY];
        case (act)
            ACT_RESET:
                return timing[CFG_RESET_LOW] + timing[CFG_PRESENCE_WAIT] +
                       timing[CFG_RESET_TAIL];
            ACT_WRITE: return BYTE_BITS * wr_slot;
            ACT_READB: return BYTE_BITS * rd_slot;
            default: return rd_slot;
        endcase
    endfunction

    // A command and the ticks that carry it through; optional stray commands
    // in between, optionally cut short
    task automatic push_op(logic [2:0] act, logic [7:0] data, bit noisy, bit cut,
                           output int counted);
        int n;
        int k;
        n = ticks_for(act);
        if (cut && n > 1)
            n = $urandom_range(0, n - 1);
        push_word(act, data, 1'($urandom_range(0, 1)));
        counted = 1 + n;
        for (k = 0; k < n; k++) begin
            if (noisy && $urandom_range(0, 99) < 5) begin
                push_word(3'($urandom_range(ACT_RESET, ACT_READ1)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                counted++;
            end
            if (noisy && $urandom_range(0, 99) < 2)
                push_word(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            push_word(ACT_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (words_taken != words_queued || results_checked != words_taken);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // drain, then tick until the sequencer is back to idle
    task automatic settle_idle();
        wait_drained();
        while (bm_phase != PH_IDLE) begin
            @(posedge i_clk);
            push_word(ACT_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            wait_drained();
        end
    endtask

    task automatic set_timing(logic [2:0] idx, int val);
        logic [9:0] v;
        v = 10'(val & reg_max(idx));
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= v;
        timing[idx] = v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic int pick_len(logic [2:0] idx);
        int lo;
        int hi;
        int r;
        lo = reg_min(idx);
        hi = reg_max(idx);
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(lo, lo + 3);
        if (r < 95)
            return $urandom_range(lo, lo + 12);
        return $urandom_range(lo, (hi > 60) ? 60 : hi);
    endfunction

    initial begin : stim
        int n;
        int count;
        int p;
        int i;
        int r;
        logic [2:0] a;
        logic [7:0] d;

        timing[CFG_RESET_LOW] = 10'd480;
        timing[CFG_PRESENCE_WAIT] = 10'd100;
        timing[CFG_RESET_TAIL] = 10'd380;
        timing[CFG_SLOT_LOW] = 10'd2;
        timing[CFG_READ_SAMPLE] = 10'd10;
        timing[CFG_READ_TAIL] = 10'd49;
        timing[CFG_WRITE_HOLD] = 10'd58;
        timing[CFG_RECOVERY] = 10'd1;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // power-on timing: one bit read with optional stray commands
        @(posedge i_clk);
        push_op(ACT_READ1, 8'hFF, 1'b1, 1'b0, n);
        settle_idle();

        // shortest timing, zero-length phases where allowed
        for (i = 0; i < 8; i++)
            set_timing(3'(i), reg_min(3'(i)));
        settings_used++;
        @(posedge i_clk);
        push_word(ACT_TICK, 8'hFF, 1'b1);
        push_word(ACT_SPARE_LO, 8'h00, 1'b0);
        push_word(ACT_SPARE_MID, 8'hFF, 1'b1);
        push_word(ACT_SPARE_HI, 8'h55, 1'b0);
        // device answers the reset
        push_word(ACT_RESET, 8'h00, 1'b1);
        push_word(ACT_TICK, 8'hAA, 1'b1);
        push_word(ACT_TICK, 8'h55, 1'b0);
        // no device on the bus
        push_word(ACT_RESET, 8'hFF, 1'b0);
        push_word(ACT_TICK, 8'h00, 1'b0);
        push_word(ACT_TICK, 8'hFF, 1'b1);
        push_op(ACT_WRITE, 8'h00, 1'b1, 1'b0, n);
        push_op(ACT_WRITE, 8'hFF, 1'b1, 1'b0, n);
        push_op(ACT_WRITE, 8'hA5, 1'b0, 1'b0, n);
        // a byte read, then every command while busy, plus a spare code
        push_word(ACT_READB, 8'h00, 1'b0);
        push_word(ACT_RESET, 8'h11, 1'b1);
        push_word(ACT_WRITE, 8'h22, 1'b0);
        push_word(ACT_READB, 8'h33, 1'b1);
        push_word(ACT_READ1, 8'h44, 1'b0);
        push_word(ACT_SPARE_HI, 8'h66, 1'b1);
        repeat (ticks_for(ACT_READB))
            push_word(ACT_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        // single-bit reads of both levels
        push_word(ACT_READ1, 8'h00, 1'b0);
        push_word(ACT_TICK, 8'h00, 1'b0);
        push_word(ACT_TICK, 8'h00, 1'b1);
        push_word(ACT_READ1, 8'hFF, 1'b1);
        push_word(ACT_TICK, 8'hFF, 1'b1);
        push_word(ACT_TICK, 8'hFF, 1'b0);
        settle_idle();

        // longest timing: one full-length bit read slot
        for (i = 0; i < 8; i++)
            set_timing(3'(i), reg_max(3'(i)));
        settings_used++;
        send_idle <= 1'b0;
        @(posedge i_clk);
        push_op(ACT_READ1, 8'h7E, 1'b0, 1'b0, n);
        settle_idle();

        // random timing and random command streams
        for (p = 0; p < RANDOM_PHASES; p++) begin
            for (i = 0; i < 8; i++)
                set_timing(3'(i), pick_len(3'(i)));
            settings_used++;
            send_idle <= (p == 1 || p == 3);
            recv_idle <= (p != 2);
            if (p == 0 || p == 3)
                hold_reqs <= hold_reqs + 1;
            @(posedge i_clk);
            count = 0;
            while (count < WORDS_PER_PHASE) begin
                a = 3'($urandom_range(ACT_RESET, ACT_READ1));
                r = $urandom_range(0, 99);
                d = (r < 10) ? 8'h00 : (r < 20) ? 8'hFF : 8'($urandom_range(0, 255));
                push_op(a, d, 1'b1, $urandom_range(0, 99) < 6, n);
                count += n;
                // idle filler: ticks and spare codes between operations
                if ($urandom_range(0, 99) < 15)
                    repeat ($urandom_range(1, 3))
                        push_word($urandom_range(0, 1) ? ACT_TICK :
                                  3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)),
                                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            settle_idle();
        end

        repeat (10) @(negedge i_clk);
        $display("Covered %0d words over %0d timing settings: %0d commands, %0d rejected",
                 words_taken, settings_used, cmds_started, cmds_rejected);
        $display("%0d operations finished, resets with device %0d / without %0d",
                 ops_done, pres_yes, pres_no);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            if (result_q.size() != 0)
                $display("%0t: %0d expected results never arrived", $time, result_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/owbm_pkg.sv
hw/rtl/one_wire_bus_master_unit.sv
hw/rtl/owbm_checker.sv
bench/tb_top.sv
